[rtl/pssr_pkg.sv]
// shared types and constants for the pulse speed step regulator
`timescale 1ns / 1ps
`default_nettype none

package pssr_pkg;

  // widths of the item and result fields
  localparam int unsigned ValW    = 16;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned DigitW  = 4;
  localparam int unsigned ActionW = 2;
  localparam int unsigned CfgIdxW = 8;

  // stream packing
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 40;
  localparam int unsigned OutUserW = 3;

  // event kinds
  typedef enum logic [ActionW-1:0] {
    ACT_RX_BYTE = 2'd0,
    ACT_PULSE   = 2'd1,
    ACT_TICK    = 2'd2,
    ACT_UNUSED  = 2'd3
  } action_e;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegDutyMax    = 8'd0;
  localparam logic [CfgIdxW-1:0] RegCoarseStep = 8'd1;

  // register reset values
  localparam logic [ValW-1:0] DutyMaxRst    = 16'd499;
  localparam logic [ValW-1:0] CoarseStepRst = 16'd50;

  // character codes and step limits
  localparam logic [ByteW-1:0] CharZero  = 8'd48;
  localparam logic [ByteW-1:0] CharNine  = 8'd57;
  localparam logic [ByteW-1:0] CharCr    = 8'd13;
  localparam logic [ValW-1:0]  FineLimit = 16'd5;
  localparam logic [ValW-1:0]  MaxVal    = 16'hFFFF;

  // regulator state
  typedef struct packed {
    logic [ValW-1:0] digit_acc;
    logic [ValW-1:0] target_speed;
    logic [ValW-1:0] pulse_count;
    logic [ValW-1:0] duty_value;
    logic            armed;
  } reg_state_t;

  // configuration registers
  typedef struct packed {
    logic [ValW-1:0] duty_max;
    logic [ValW-1:0] coarse_down_step;
  } reg_cfg_t;

  // one result word
  typedef struct packed {
    logic              echo_valid;
    logic [DigitW-1:0] echo_digit;
    logic              setpoint_done;
    logic              speed_valid;
    logic [ValW-1:0]   measured_speed;
    logic [ValW-1:0]   duty;
  } reg_result_t;

endpackage

`default_nettype wire

[rtl/pssr_core.sv]
// event evaluation: next regulator state and the result word for one event
`timescale 1ns / 1ps
`default_nettype none

module pssr_core (
  input  pssr_pkg::reg_state_t              state_i,
  input  pssr_pkg::reg_cfg_t                cfg_i,
  input  logic [pssr_pkg::ActionW-1:0]      action_i,
  input  logic [pssr_pkg::ByteW-1:0]        rx_byte_i,
  output pssr_pkg::reg_state_t              state_o,
  output pssr_pkg::reg_result_t             result_o
);
  import pssr_pkg::*;

  logic              is_digit;
  logic [DigitW-1:0] digit;
  logic [ValW+3:0]   acc_wide;
  logic [ValW-1:0]   acc_sat;
  logic [ValW-1:0]   speed;
  logic [ValW-1:0]   err_up;
  logic [ValW-1:0]   err_dn;
  logic [2:0]        inc;
  logic [ValW-1:0]   dec;
  logic [ValW:0]     duty_up;
  logic [ValW-1:0]   duty_clamp;
  logic [ValW-1:0]   duty_reg;
  action_e           act;

  assign act = action_e'(action_i);

  // digit decode and decimal accumulate with saturation
  assign is_digit = (rx_byte_i >= CharZero) && (rx_byte_i <= CharNine);
  assign digit    = DigitW'(rx_byte_i - CharZero);
  assign acc_wide = ({4'd0, state_i.digit_acc} << 3) + ({4'd0, state_i.digit_acc} << 1)
                  + {16'd0, digit};
  assign acc_sat  = (acc_wide > {4'd0, MaxVal}) ? MaxVal : acc_wide[ValW-1:0];

  // tick regulation
  assign speed  = state_i.pulse_count;
  assign err_up = speed - state_i.target_speed;
  assign err_dn = state_i.target_speed - speed;

  // speed above target: fine step up to five
  always_comb begin
    if (err_up > FineLimit) begin
      inc = 3'd5;
    end else if (err_up > 16'd1) begin
      inc = 3'(err_up - 16'd1);
    end else begin
      inc = 3'd0;
    end
  end

  // speed below target: fine step or coarse step
  always_comb begin
    if (err_dn > FineLimit) begin
      dec = cfg_i.coarse_down_step;
    end else if (err_dn > 16'd1) begin
      dec = err_dn - 16'd1;
    end else begin
      dec = '0;
    end
  end

  assign duty_up    = (speed > state_i.target_speed)
                    ? {1'b0, state_i.duty_value} + {14'd0, inc}
                    : {1'b0, state_i.duty_value};
  assign duty_clamp = (duty_up > {1'b0, cfg_i.duty_max}) ? cfg_i.duty_max
                                                         : duty_up[ValW-1:0];

  always_comb begin
    if (speed < state_i.target_speed) begin
      duty_reg = (duty_clamp > dec) ? duty_clamp - dec : '0;
    end else if (speed == state_i.target_speed) begin
      duty_reg = '0;
    end else begin
      duty_reg = duty_clamp;
    end
  end

  // event dispatch
  always_comb begin
    state_o  = state_i;
    result_o = '0;
    unique case (act)
      ACT_RX_BYTE: begin
        if (is_digit) begin
          state_o.digit_acc   = acc_sat;
          result_o.echo_valid = 1'b1;
          result_o.echo_digit = digit;
        end else if (rx_byte_i == CharCr) begin
          state_o.target_speed   = state_i.digit_acc;
          state_o.digit_acc      = '0;
          state_o.armed          = 1'b1;
          result_o.setpoint_done = 1'b1;
        end
      end
      ACT_PULSE: begin
        if (state_i.pulse_count != MaxVal) begin
          state_o.pulse_count = state_i.pulse_count + 16'd1;
        end
      end
      ACT_TICK: begin
        state_o.pulse_count     = '0;
        result_o.speed_valid    = 1'b1;
        result_o.measured_speed = speed;
        if (state_i.armed) begin
          state_o.duty_value = duty_reg;
        end
      end
      default: begin
        state_o = state_i;
      end
    endcase
    result_o.duty = state_o.duty_value;
  end

endmodule

`default_nettype wire

[rtl/pulse_speed_step_regulator.sv]
// top level of the pulse speed step regulator: stream ports, registers, state
`timescale 1ns / 1ps
`default_nettype none

// Pulse speed step regulator.
// Input stream: one word per event. s_axis_tuser holds the event kind
// (received byte, pulse edge, control tick), s_axis_tdata the received byte.
// Digits build a decimal setpoint, carriage return latches it and arms the
// loop, pulse edges count, a tick reports the count and steps the PWM value.
// Output stream: exactly one result word per input word, in order.
// The word sits in the input register, then the event logic writes the output
// register. Throughput is one word per clock while the receiver does not stall;
// the state update is a single pass of compare and add logic between the input
// and output registers.
// When the receiver stalls, the output register holds its word and the input
// register takes one more word, after which s_axis_tready drops.
// Configuration writes (duty max, coarse down step) are always taken and must
// arrive while no event is in flight. Reset clears all state and the pipeline
// and loads the register defaults.
module pulse_speed_step_regulator (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // input stream
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [pssr_pkg::InDataW-1:0]         s_axis_tdata,  // [7:0] rx_byte
  input  logic [pssr_pkg::ActionW-1:0]         s_axis_tuser,  // [1:0] action
  // output stream
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // [3:0] echo_digit, [19:4] measured_speed, [35:20] duty, [39:36] zero
  output logic [pssr_pkg::OutDataW-1:0]        m_axis_tdata,
  // [0] echo_valid, [1] setpoint_done, [2] speed_valid
  output logic [pssr_pkg::OutUserW-1:0]        m_axis_tuser,
  // configuration writes
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [pssr_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [pssr_pkg::ValW-1:0]            cfg_data_i
);
  import pssr_pkg::*;

  logic               in_valid_q;
  logic [ActionW-1:0] in_action_q;
  logic [ByteW-1:0]   in_byte_q;
  logic               out_valid_q;
  reg_result_t        out_res_q;
  reg_result_t        res_d;
  reg_state_t         state_q;
  reg_state_t         state_d;
  reg_cfg_t           cfg_q;
  logic               advance;

  // the input word moves on when the output register is free or drains
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign cfg_ready_o   = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.duty_max         <= DutyMaxRst;
      cfg_q.coarse_down_step <= CoarseStepRst;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == RegDutyMax) begin
        cfg_q.duty_max <= cfg_data_i;
      end else if (cfg_index_i == RegCoarseStep) begin
        cfg_q.coarse_down_step <= cfg_data_i;
      end
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_action_q <= s_axis_tuser;
      in_byte_q   <= s_axis_tdata;
    end
  end

  // event logic
  pssr_core u_core (
    .state_i   (state_q),
    .cfg_i     (cfg_q),
    .action_i  (in_action_q),
    .rx_byte_i (in_byte_q),
    .state_o   (state_d),
    .result_o  (res_d)
  );

  // regulator state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_res_q <= res_d;
    end
  end

  // output packing
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'd0, out_res_q.duty, out_res_q.measured_speed,
                          out_res_q.echo_digit};
  assign m_axis_tuser  = {out_res_q.speed_valid, out_res_q.setpoint_done,
                          out_res_q.echo_valid};

endmodule

`default_nettype wire

[bench/tb_top.sv]
// self-checking bench for the pulse speed step regulator: stream traffic, register writes, checks
`timescale 1ns / 1ps

module tb_top;
  import pssr_pkg::*;

  // one row of the directed sequence
  typedef struct {
    action_e     act;
    logic [7:0]  rx;
    bit          typed;
    reg_result_t want;
  } stim_row_t;

  // clock and reset
  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // event stream into the block
  logic                ev_valid = 1'b0;
  logic                ev_ready;
  logic [InDataW-1:0]  ev_byte = '0;
  action_e             ev_kind = ACT_RX_BYTE;

  // result stream out of the block
  logic                res_valid;
  logic                res_ready = 1'b0;
  logic [OutDataW-1:0] res_data;
  logic [OutUserW-1:0] res_user;

  // register write channel
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [ValW-1:0]     cfg_data = '0;

  // traffic shaping
  int unsigned send_idle = 0;
  int unsigned stall_pct = 0;
  logic        hold_req = 1'b0;

  // regulator mirror: state and registers as the block should hold them
  logic [ValW-1:0] acc_q = '0;
  logic [ValW-1:0] target_q = '0;
  logic [ValW-1:0] pulses_q = '0;
  logic [ValW-1:0] duty_q = '0;
  logic            armed_q = 1'b0;
  reg_cfg_t        cfg_q = '{duty_max: DutyMaxRst, coarse_down_step: CoarseStepRst};

  reg_result_t due_results[$];
  stim_row_t   directed_rows[$];
  int unsigned mismatch_cnt = 0;

  pulse_speed_step_regulator dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (ev_valid),
    .s_axis_tready (ev_ready),
    .s_axis_tdata  (ev_byte),
    .s_axis_tuser  (ev_kind),
    .m_axis_tvalid (res_valid),
    .m_axis_tready (res_ready),
    .m_axis_tdata  (res_data),
    .m_axis_tuser  (res_user),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  always #10 clk = ~clk;

  // apply one event to the mirror and return the word the block should send
  function automatic reg_result_t step_regulator(action_e act, logic [ByteW-1:0] rx);
    reg_result_t r;
    int unsigned dig, num, d, e, dec;
    r = '0;
    case (act)
      ACT_RX_BYTE: begin
        if (rx >= CharZero && rx <= CharNine) begin
          dig = rx - CharZero;
          num = 32'(acc_q) * 10 + dig;
          acc_q = (num > MaxVal) ? MaxVal : num[ValW-1:0];
          r.echo_valid = 1'b1;
          r.echo_digit = dig[DigitW-1:0];
        end else if (rx == CharCr) begin
          target_q = acc_q;
          acc_q = '0;
          armed_q = 1'b1;
          r.setpoint_done = 1'b1;
        end
      end
      ACT_PULSE: begin
        if (pulses_q != MaxVal) pulses_q = pulses_q + 1'b1;
      end
      ACT_TICK: begin
        r.speed_valid = 1'b1;
        r.measured_speed = pulses_q;
        if (armed_q) begin
          d = duty_q;
          // too fast: raise by the fine step, then clamp
          if (pulses_q > target_q) begin
            e = 32'(pulses_q) - 32'(target_q);
            if (e > FineLimit) d = d + FineLimit;
            else if (e > 1) d = d + e - 1;
          end
          if (d > cfg_q.duty_max) d = cfg_q.duty_max;
          // too slow: fine or coarse drop, floor at zero
          if (pulses_q < target_q) begin
            e = 32'(target_q) - 32'(pulses_q);
            dec = 0;
            if (e > FineLimit) dec = cfg_q.coarse_down_step;
            else if (e > 1) dec = e - 1;
            d = (d > dec) ? d - dec : 0;
          end
          if (pulses_q == target_q) d = 0;
          duty_q = d[ValW-1:0];
        end
        pulses_q = '0;
      end
      default: begin
      end
    endcase
    r.duty = duty_q;
    return r;
  endfunction

  task automatic flag_error(string msg);
    if (mismatch_cnt < 40) $display("%0t ns: %s", $time, msg);
    mismatch_cnt++;
  endtask

  task automatic check_field(string what, logic [ValW-1:0] seen, logic [ValW-1:0] want);
    if (seen !== want) flag_error($sformatf("%s got %0h expected %0h", what, seen, want));
  endtask

  // offer one event word, with random idle cycles ahead of it
  task automatic offer(action_e act, logic [ByteW-1:0] rx);
    if ($urandom_range(99) < send_idle) begin
      ev_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    ev_valid <= 1'b1;
    ev_kind <= act;
    ev_byte <= rx;
    do @(posedge clk); while (!ev_ready);
    due_results.push_back(step_regulator(act, rx));
  endtask

  task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [ValW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == RegDutyMax) cfg_q.duty_max = val;
    else if (idx == RegCoarseStep) cfg_q.coarse_down_step = val;
  endtask

  task automatic program_regs(logic [ValW-1:0] cap, logic [ValW-1:0] coarse);
    cfg_write(RegDutyMax, cap);
    cfg_write(RegCoarseStep, coarse);
    // an index past the register list must change nothing
    cfg_write(8'($urandom_range(2, 255)), 16'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // wait until every expected word is back, then a few more cycles
  task automatic settle;
    int unsigned guard;
    guard = 0;
    while (due_results.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    if (due_results.size() != 0) begin
      flag_error($sformatf("%0d result words never arrived", due_results.size()));
      due_results.delete();
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic add_row(action_e act, logic [7:0] rx, bit typed, logic ev, logic [3:0] dg,
                         logic dn, logic sv, logic [15:0] spd);
    stim_row_t row;
    row.act = act;
    row.rx = rx;
    row.typed = typed;
    row.want = '0;
    row.want.echo_valid = ev;
    row.want.echo_digit = dg;
    row.want.setpoint_done = dn;
    row.want.speed_valid = sv;
    row.want.measured_speed = spd;
    directed_rows.push_back(row);
  endtask

  // mostly setpoints and control periods near the target, some noise
  task automatic random_traffic(int unsigned count);
    int unsigned fed, n, k, pick;
    int len, j;
    string digits;
    fed = 0;
    while (fed < count) begin
      pick = $urandom_range(99);
      if (pick < 15) begin
        if ($urandom_range(7) == 0) begin
          // long number, may saturate the accumulator
          n = $urandom_range(5, 7);
          repeat (n) offer(ACT_RX_BYTE, 8'(CharZero + $urandom_range(9)));
          fed += n;
        end else begin
          digits = $sformatf("%0d", $urandom_range(24));
          for (k = 0; k < digits.len(); k++) begin
            offer(ACT_RX_BYTE, digits[k]);
            // stray byte inside the number
            if ($urandom_range(9) == 0) offer(ACT_RX_BYTE, 8'($urandom));
          end
          fed += digits.len();
        end
        offer(ACT_RX_BYTE, CharCr);
        fed++;
      end else if (pick < 25) begin
        // noise: any kind, any byte
        offer(action_e'($urandom_range(3)), 8'($urandom));
        fed++;
      end else begin
        // one control period with a pulse count around the target, or up to 30 pulses above 40
        if (target_q > 40) len = $urandom_range(30);
        else len = int'(target_q) + int'($urandom_range(16)) - 8;
        for (j = 0; j < len; j++) offer(ACT_PULSE, 8'($urandom));
        offer(ACT_TICK, 8'($urandom));
        fed += (len > 0) ? len + 1 : 1;
      end
    end
  endtask

  // receiver ready: random stalls, and a long hold-off on request
  initial begin : sink_ready
    forever begin
      @(posedge clk);
      if (hold_req) begin
        res_ready <= 1'b0;
        hold_req <= 1'b0;
        repeat (300) @(posedge clk);
      end else begin
        res_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // compare each accepted word with the oldest expectation
  always @(posedge clk) begin : result_check
    reg_result_t seen, want;
    if (rst_n && res_valid && res_ready) begin
      seen.echo_valid = res_user[0];
      seen.setpoint_done = res_user[1];
      seen.speed_valid = res_user[2];
      seen.echo_digit = res_data[3:0];
      seen.measured_speed = res_data[19:4];
      seen.duty = res_data[35:20];
      check_field("pad bits", res_data[39:36], '0);
      if (due_results.size() == 0) begin
        flag_error("result word with nothing expected");
      end else begin
        want = due_results.pop_front();
        check_field("echo_valid", seen.echo_valid, want.echo_valid);
        check_field("echo_digit", seen.echo_digit, want.echo_digit);
        check_field("setpoint_done", seen.setpoint_done, want.setpoint_done);
        check_field("speed_valid", seen.speed_valid, want.speed_valid);
        check_field("measured_speed", seen.measured_speed, want.measured_speed);
        check_field("duty", seen.duty, want.duty);
      end
    end
  end

  initial begin : watchdog
    #20ms;
    $display("[pulse_speed_step_regulator] ERROR");
    $finish;
  end

  initial begin : stimulus
    int ph;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    program_regs(DutyMaxRst, CoarseStepRst);

    // directed: ignored codes, digit edges, saturation, latch, match and fine steps
    add_row(ACT_TICK, 8'h00, 1, 0, 0, 0, 1, 0);
    add_row(ACT_UNUSED, 8'hFF, 1, 0, 0, 0, 0, 0);
    add_row(ACT_RX_BYTE, 8'h2F, 1, 0, 0, 0, 0, 0);
    add_row(ACT_RX_BYTE, 8'h3A, 1, 0, 0, 0, 0, 0);
    add_row(ACT_RX_BYTE, 8'h80, 1, 0, 0, 0, 0, 0);
    add_row(ACT_RX_BYTE, CharZero, 1, 1, 0, 0, 0, 0);
    repeat (6) add_row(ACT_RX_BYTE, CharNine, 1, 1, 9, 0, 0, 0);
    add_row(ACT_RX_BYTE, CharCr, 1, 0, 0, 1, 0, 0);
    repeat (2) add_row(ACT_PULSE, 8'hFF, 1, 0, 0, 0, 0, 0);
    add_row(ACT_TICK, 8'h55, 0, 0, 0, 0, 0, 0);
    add_row(ACT_RX_BYTE, 8'(CharZero + 2), 1, 1, 2, 0, 0, 0);
    add_row(ACT_RX_BYTE, CharCr, 1, 0, 0, 1, 0, 0);
    repeat (2) add_row(ACT_PULSE, 8'hAA, 1, 0, 0, 0, 0, 0);
    add_row(ACT_TICK, 8'h00, 0, 0, 0, 0, 0, 0);
    add_row(ACT_TICK, 8'hFF, 0, 0, 0, 0, 0, 0);
    foreach (directed_rows[k]) begin
      offer(directed_rows[k].act, directed_rows[k].rx);
      if (directed_rows[k].typed) due_results[due_results.size() - 1] = directed_rows[k].want;
    end
    ev_valid <= 1'b0;
    settle();

    // random phases, each with its own registers and idling
    for (ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle = 0;  stall_pct = 0;  program_regs(DutyMaxRst, CoarseStepRst); end
        1: begin send_idle = 49; stall_pct = 0;  program_regs(16'd1, 16'd0); end
        2: begin send_idle = 0;  stall_pct = 49; program_regs(16'hFFFF, 16'hFFFF); end
        3: begin send_idle = 28; stall_pct = 28; program_regs(16'd20, 16'd3); end
        default: begin
          send_idle = 28;
          stall_pct = 28;
          program_regs(16'($urandom_range(1, 600)), 16'($urandom_range(0, 80)));
        end
      endcase
      random_traffic(165);
      // sender pauses until everything is back
      ev_valid <= 1'b0;
      settle();
      if (ph == 3) hold_req <= 1'b1;
      random_traffic(165);
      ev_valid <= 1'b0;
      settle();
    end

    if (mismatch_cnt == 0) begin
      $display("[pulse_speed_step_regulator] OK");
    end else begin
      $display("[pulse_speed_step_regulator] ERROR");
    end
    $finish;
  end

endmodule
